[src/assert_macros.svh]
// Assertion macros shared by the classifier RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check on the rising clock edge, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
// Concurrent check on the rising clock edge that is never disabled.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[src/knn_pkg.sv]
// Package with the sizes, types and interface codes of the k-nearest-neighbor classifier.
`default_nettype none

package knn_pkg;

    localparam int VECTOR_LENGTH = 784;
    localparam int MAX_NEIGHBORS = 8;
    localparam int NUM_CLASSES   = 10;

    localparam int PIX_W   = 8;
    localparam int LABEL_W = 4;
    localparam int CFG_W   = 4;
    localparam int OUT_W   = 4;
    localparam int DIST_W  = 26;
    localparam int SQ_W    = 2 * PIX_W;
    localparam int IDX_W   = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int CLASS_W = $clog2(NUM_CLASSES);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam int TUSER_ACTION     = 0;
    localparam int TUSER_END_OF_SET = 1;

    localparam logic ACTION_QUERY = 1'b0;
    localparam logic ACTION_TRAIN = 1'b1;

    localparam logic [CFG_W-1:0] NEIGHBOR_COUNT_RESET = 4'd3;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [OUT_W-1:0]   field_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CLASS_W-1:0] class_t;

    localparam dist_t DIST_MAX = {DIST_W{1'b1}};

    // A training pixel after the input register.
    typedef struct packed {
        logic   valid;
        logic   last;
        logic   vote;
        label_t label;
        pix_t   pixel;
    } p1_t;

    // A finished sample distance offered to the neighbor list.
    typedef struct packed {
        logic   valid;
        logic   vote;
        dist_t  distance;
        label_t label;
    } ins_req_t;

    // The kept neighbors as seen by the vote stage.
    typedef struct packed {
        logic                        vote;
        cnt_t                        used;
        label_t [MAX_NEIGHBORS-1:0]  labels;
    } list_view_t;

endpackage

`default_nettype wire

[src/knn_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 784,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/knn_dist.sv]
// Squared-difference stage and saturating distance accumulator.
`default_nettype none

module knn_dist import knn_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire p1_t      p1,
    input  wire pix_t     query_pixel,
    output ins_req_t      ins
);

    p1_t      p2_reg;
    sq_t      sq_reg;
    sq_t      sq_next;
    pix_t     diff;
    dist_t    acc_reg;
    dist_t    acc_next;
    dist_t    sat_sum;
    logic [DIST_W:0] sum;
    ins_req_t ins_reg;
    ins_req_t ins_next;

    always_comb begin
        diff    = (p1.pixel > query_pixel) ? (p1.pixel - query_pixel)
                                           : (query_pixel - p1.pixel);
        sq_next = SQ_W'(diff) * SQ_W'(diff);
    end

    always_comb begin
        sum     = {1'b0, acc_reg} + (DIST_W + 1)'(sq_reg);
        sat_sum = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        acc_next = acc_reg;
        if (p2_reg.valid) begin
            acc_next = p2_reg.last ? '0 : sat_sum;
        end
        ins_next.valid    = p2_reg.valid && p2_reg.last;
        ins_next.vote     = p2_reg.vote;
        ins_next.distance = sat_sum;
        ins_next.label    = p2_reg.label;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_reg  <= '0;
            acc_reg <= '0;
            ins_reg <= '0;
        end else if (en) begin
            p2_reg  <= p1;
            acc_reg <= acc_next;
            ins_reg <= ins_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign ins = ins_reg;

endmodule

`default_nettype wire

[src/knn_topk.sv]
// Sorted list of the nearest kept neighbors; each insertion shifts the larger entries down.
`default_nettype none
`include "assert_macros.svh"

module knn_topk import knn_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire cfg_t     k_cfg,
    input  wire ins_req_t ins,
    output list_view_t    view
);

    dist_t  dist_reg   [MAX_NEIGHBORS];
    dist_t  dist_next  [MAX_NEIGHBORS];
    label_t label_reg  [MAX_NEIGHBORS];
    label_t label_next [MAX_NEIGHBORS];
    cnt_t   kept_reg;
    cnt_t   kept_next;
    logic   vote_reg;
    cnt_t   k;
    cnt_t   n;
    cnt_t   pos;
    logic [CNT_W:0] n_inc;

    always_comb begin
        if (k_cfg == '0) begin
            k = CNT_W'(1);
        end else if (int'(k_cfg) > MAX_NEIGHBORS) begin
            k = CNT_W'(MAX_NEIGHBORS);
        end else begin
            k = CNT_W'(k_cfg);
        end
    end

    // A vote in the stage ahead empties the list, so an insert in the same
    // cycle starts from an empty list.
    always_comb begin
        n = vote_reg ? '0 : ((kept_reg < k) ? kept_reg : k);
        pos = '0;
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            if (CNT_W'(i) < n && dist_reg[i] < ins.distance) begin
                pos = pos + CNT_W'(1);
            end
        end
        n_inc = {1'b0, n} + (CNT_W + 1)'(1);
    end

    always_comb begin
        dist_next  = dist_reg;
        label_next = label_reg;
        kept_next  = kept_reg;
        if (ins.valid) begin
            if (pos >= k) begin
                kept_next = n;
            end else begin
                for (int j = 1; j < MAX_NEIGHBORS; j++) begin
                    if (CNT_W'(j) > pos) begin
                        dist_next[j]  = dist_reg[j-1];
                        label_next[j] = label_reg[j-1];
                    end
                end
                for (int j = 0; j < MAX_NEIGHBORS; j++) begin
                    if (CNT_W'(j) == pos) begin
                        dist_next[j]  = ins.distance;
                        label_next[j] = ins.label;
                    end
                end
                kept_next = (n_inc < {1'b0, k}) ? n_inc[CNT_W-1:0] : k;
            end
        end else if (vote_reg) begin
            kept_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg <= '0;
            vote_reg <= 1'b0;
        end else if (en) begin
            kept_reg <= kept_next;
            vote_reg <= ins.valid && ins.vote;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg  <= dist_next;
            label_reg <= label_next;
        end
    end

    always_comb begin
        view.vote = vote_reg;
        view.used = (kept_reg < k) ? kept_reg : k;
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            view.labels[i] = label_reg[i];
        end
    end

    `ASSERT_PROP(a_kept_bound, aclk, aresetn, int'(kept_reg) <= MAX_NEIGHBORS)
    `ASSERT_PROP(a_clear_after_vote, aclk, aresetn, (en && vote_reg && !ins.valid) |=> kept_reg == '0)

endmodule

`default_nettype wire

[src/knn_vote.sv]
// Class vote counting, majority selection and the result output register.
`default_nettype none

module knn_vote import knn_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire list_view_t            view,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       blocked
);

    cnt_t   counts_reg  [NUM_CLASSES];
    cnt_t   counts_next [NUM_CLASSES];
    cnt_t   used_reg;
    logic   cnt_valid_reg;
    class_t best;
    logic   m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            counts_next[c] = '0;
            for (int i = 0; i < MAX_NEIGHBORS; i++) begin
                if (CNT_W'(i) < view.used && view.labels[i] == LABEL_W'(c)) begin
                    counts_next[c] = counts_next[c] + CNT_W'(1);
                end
            end
        end
    end

    // Strictly greater wins, so a tie keeps the lower class.
    always_comb begin
        best = '0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (counts_reg[c] > counts_reg[best]) begin
                best = CLASS_W'(c);
            end
        end
        m_tdata_next = {(M_TDATA_W - 3 * OUT_W)'(0), OUT_W'(used_reg),
                        OUT_W'(counts_reg[best]), OUT_W'(best)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (en) begin
                cnt_valid_reg <= view.vote;
            end
            if (cnt_valid_reg && en) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            counts_reg <= counts_next;
            used_reg   <= view.used;
        end
        if (cnt_valid_reg && en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign blocked  = cnt_valid_reg && m_tvalid_reg && !m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[src/knn_classifier.sv]
// A result passes the input, difference, distance, list, vote-count and output registers.
// One pixel per cycle unless stalled; the query store takes a write and a read a cycle.
// s_tready drops only while a finished result waits and the next result is ready behind it.
// Reset is synchronous and active low; it clears the pipeline, the kept list and sets k to 3.
// The query store is not cleared by reset and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module knn_classifier import knn_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [7:0] pixel_value, [11:8] sample_label, [15:12] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // end_of_sample
    input  wire logic                  s_tlast,
    // [0] action, [1] end_of_set
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [3:0] predicted_class, [7:4] winning_votes, [11:8] neighbors_used, [15:12] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    logic       en;
    logic       blocked;
    logic       accept;
    logic       is_query;
    logic       is_train;
    logic       sample_end;
    pix_t       in_pixel;
    label_t     in_label;
    idx_t       idx_reg;
    idx_t       idx_next;
    idx_t       idx_adv;
    cfg_t       k_reg;
    p1_t        p1_reg;
    p1_t        p1_next;
    pix_t       query_pixel;
    ins_req_t   ins;
    list_view_t view;
    field_t     out_votes;
    field_t     out_used;

    assign en        = !blocked;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && en;
    assign in_pixel  = s_tdata[PIX_W-1:0];
    assign in_label  = s_tdata[PIX_W+LABEL_W-1:PIX_W];
    assign is_query  = accept && (s_tuser[TUSER_ACTION] == ACTION_QUERY);
    assign is_train  = accept && (s_tuser[TUSER_ACTION] == ACTION_TRAIN);
    assign sample_end = s_tlast || s_tuser[TUSER_END_OF_SET];

    always_comb begin
        idx_adv  = (idx_reg == IDX_W'(VECTOR_LENGTH - 1)) ? '0 : idx_reg + IDX_W'(1);
        idx_next = idx_reg;
        if (is_query) begin
            idx_next = s_tlast ? '0 : idx_adv;
        end else if (is_train) begin
            idx_next = sample_end ? '0 : idx_adv;
        end
        p1_next.valid = is_train;
        p1_next.last  = sample_end;
        p1_next.vote  = s_tuser[TUSER_END_OF_SET];
        p1_next.label = in_label;
        p1_next.pixel = in_pixel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            k_reg   <= NEIGHBOR_COUNT_RESET;
            p1_reg  <= '0;
        end else begin
            idx_reg <= idx_next;
            if (cfg_valid) begin
                k_reg <= cfg_data;
            end
            if (en) begin
                p1_reg <= p1_next;
            end
        end
    end

    knn_ram #(
        .WIDTH (PIX_W),
        .DEPTH (VECTOR_LENGTH)
    ) u_query_ram (
        .aclk    (aclk),
        .wr_en   (is_query),
        .wr_addr (idx_reg),
        .wr_data (in_pixel),
        .rd_en   (en),
        .rd_addr (idx_reg),
        .rd_data (query_pixel)
    );

    knn_dist u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .p1          (p1_reg),
        .query_pixel (query_pixel),
        .ins         (ins)
    );

    knn_topk u_topk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .k_cfg   (k_reg),
        .ins     (ins),
        .view    (view)
    );

    knn_vote u_vote (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .view     (view),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .blocked  (blocked)
    );

    assign out_votes = m_tdata[2*OUT_W-1:OUT_W];
    assign out_used  = m_tdata[3*OUT_W-1:2*OUT_W];

    `ASSERT_PROP(a_idx_range, aclk, aresetn, idx_reg <= IDX_W'(VECTOR_LENGTH - 1))
    `ASSERT_PROP(a_votes_le_used, aclk, aresetn, m_tvalid |-> (out_votes <= out_used))
    `ASSERT_PROP(a_stall_cause, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready))

endmodule

`default_nettype wire
